// ----- sv/mcpt_pkg.sv -----
package mcpt_pkg;

    // Field widths of the request and result channels.
    localparam int FUNC_W     = 1;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int MASK_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int HIT_W      = 16;

    // Default coil count.
    localparam int NOTES_DEF  = 32;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_STRIKE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_NOTE = 2'd0;
    localparam logic [1:0] REG_HIT_TIME   = 2'd1;
    localparam logic [1:0] REG_MIN_PWM    = 2'd2;
    localparam logic [1:0] REG_NOTE_EN    = 2'd3;

    // Register reset values.
    localparam logic [NOTE_W-1:0] START_NOTE_RST = 7'd60;
    localparam logic [HIT_W-1:0]  HIT_TIME_RST   = 16'd30;
    localparam logic [DUTY_W-1:0] MIN_PWM_RST    = 8'd0;
    localparam logic [MASK_W-1:0] NOTE_EN_RST    = 32'hFFFF_FFFF;

    // Duty scaling: min_pwm + velocity * (DUTY_MAX - min_pwm) / VEL_MAX.
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
    localparam logic [DUTY_W-1:0] VEL_MAX  = 8'd127;
    localparam int                PROD_W   = VEL_W + DUTY_W;

    // Division by VEL_MAX as (p * VEL_RECIP) >> RECIP_SH. The result is exact
    // for every product p below 33554, which covers 127 * 255.
    localparam int                 RECIP_W   = 16;
    localparam logic [RECIP_W-1:0] VEL_RECIP = 16'd33027;
    localparam int                 RECIP_SH  = 22;
    localparam int                 SCALE_W   = PROD_W + RECIP_W;

endpackage

// ----- sv/mcpt_if.sv -----
// Request channel: one strike or one millisecond tick.
interface mcpt_req_if;
    import mcpt_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    velocity;

    modport source (output valid, output func, output note, output velocity, input ready);
    modport sink   (input valid, input func, input note, input velocity, output ready);
endinterface

// Result channel: coil state and drive duty after each request.
interface mcpt_res_if;
    import mcpt_pkg::*;
    logic                valid;
    logic                ready;
    logic [MASK_W-1:0]   coil_mask;
    logic [DUTY_W-1:0]   drive_duty;
    logic                strike_taken;

    modport source (output valid, output coil_mask, output drive_duty, output strike_taken,
                    input ready);
    modport sink   (input valid, input coil_mask, input drive_duty, input strike_taken,
                    output ready);
endinterface

// ----- sv/multi_coil_pulse_timer.sv -----
// Channel    Dir   Handshake       Payload
// i_req      in    valid/ready     func, note, velocity
// o_res      out   valid/ready     coil_mask, drive_duty, strike_taken
// APB        in    psel/penable    start_note, hit_time, min_pwm, note_enable_mask
//
// A tick walks the coil counters one coil a cycle. A taken strike scales the duty
// with one reciprocal multiply; a rejected strike skips the multiply.
// i_rst_n is synchronous and active low; it clears coils, duty and registers.
// A new request is taken only in the idle state; a stalled result holds the
// finishing step until the output register frees, while a waiting result
// does not block the next request from being taken.
module multi_coil_pulse_timer #(
    parameter int NOTES = mcpt_pkg::NOTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mcpt_req_if.sink                    i_req,
    mcpt_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mcpt_pkg::*;

    localparam int IW = (NOTES > 1) ? $clog2(NOTES) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    // Configuration registers.
    logic [NOTE_W-1:0]  r_start;
    logic [HIT_W-1:0]   r_hit;
    logic [DUTY_W-1:0]  r_min;
    logic [MASK_W-1:0]  r_en;

    // Block state.
    logic [NOTES-1:0]   r_coil;
    logic [HIT_W-1:0]   r_elapsed [NOTES];
    logic [DUTY_W-1:0]  r_duty;

    // Sequencer.
    logic [2:0]         r_state;
    logic [IW-1:0]      r_idx;
    logic [PROD_W-1:0]  r_prod;
    logic               r_taken;

    // Output register.
    logic               r_ovalid;
    logic [MASK_W-1:0]  r_omask;
    logic [DUTY_W-1:0]  r_oduty;
    logic               r_otaken;

    logic               w_accept;
    logic               w_cfg_wr;
    logic [NOTE_W:0]    w_diff;
    logic               w_hit;
    logic [IW-1:0]      w_sidx;
    logic [HIT_W-1:0]   w_e;
    logic [HIT_W-1:0]   w_ne;
    logic               w_act;
    logic               w_off;
    logic [SCALE_W-1:0] w_scaled;
    logic [DUTY_W-1:0]  w_quo;
    logic               w_oload;
    logic [MASK_W-1:0]  w_mask;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_START_NOTE: prdata = 32'(r_start);
            REG_HIT_TIME:   prdata = 32'(r_hit);
            REG_MIN_PWM:    prdata = 32'(r_min);
            REG_NOTE_EN:    prdata = r_en;
            default:        prdata = '0;
        endcase
    end

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_NOTE_RST;
            r_hit   <= HIT_TIME_RST;
            r_min   <= MIN_PWM_RST;
            r_en    <= NOTE_EN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_START_NOTE: r_start <= pwdata[NOTE_W-1:0];
                REG_HIT_TIME:   r_hit   <= pwdata[HIT_W-1:0];
                REG_MIN_PWM:    r_min   <= pwdata[DUTY_W-1:0];
                REG_NOTE_EN:    r_en    <= pwdata;
                default:        ;
            endcase
        end
    end

    // Strike decode: the note's coil index and whether it is fitted.
    always_comb begin
        w_diff = {1'b0, i_req.note} - {1'b0, r_start};
        w_sidx = w_diff[IW-1:0];
        w_hit  = !w_diff[NOTE_W] && (w_diff[NOTE_W-1:0] < NOTE_W'(NOTES))
                 && r_en[w_sidx];
    end

    // Shared counter unit: advance one coil's elapsed time and test it.
    always_comb begin
        w_act = r_coil[r_idx];
        w_e   = r_elapsed[r_idx];
        w_ne  = (w_e < r_hit) ? w_e + HIT_W'(1) : w_e;
        w_off = !(w_ne < r_hit);
    end

    // Duty quotient: the product over 127 by reciprocal multiplication.
    always_comb begin
        w_scaled = SCALE_W'(r_prod) * SCALE_W'(VEL_RECIP);
        w_quo    = w_scaled[RECIP_SH +: DUTY_W];
    end

    // Coil mask widened to the port.
    always_comb begin
        w_mask = '0;
        w_mask[NOTES-1:0] = r_coil;
    end

    assign w_oload = (r_state == ST_OUT) && (!r_ovalid || o_res.ready);

    // Elapsed counters: cleared by a strike, advanced by the tick sweep.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.func == FUNC_STRIKE) && w_hit) begin
            r_elapsed[w_sidx] <= '0;
        end else if ((r_state == ST_TICK) && w_act) begin
            r_elapsed[r_idx] <= w_ne;
        end
    end

    // Sequencer, coils and duty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_coil  <= '0;
            r_duty  <= '0;
            r_idx   <= '0;
            r_taken <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx  <= '0;
                        r_prod <= PROD_W'(i_req.velocity) * PROD_W'(DUTY_MAX - r_min);
                        if (i_req.func == FUNC_TICK) begin
                            r_taken <= 1'b0;
                            r_state <= ST_TICK;
                        end else if (w_hit) begin
                            r_coil[w_sidx] <= 1'b1;
                            r_taken <= 1'b1;
                            r_state <= ST_DIV;
                        end else begin
                            r_taken <= 1'b0;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_TICK: begin
                    if (w_act && w_off) begin
                        r_coil[r_idx] <= 1'b0;
                    end
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(NOTES - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    r_duty  <= r_min + w_quo;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_oload) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_omask  <= w_mask;
            r_oduty  <= r_duty;
            r_otaken <= r_taken;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.coil_mask    = r_omask;
    assign o_res.drive_duty   = r_oduty;
    assign o_res.strike_taken = r_otaken;

    // The tick sweep only ever switches coils off.
    a_tick_no_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |=> ((r_coil & ~$past(r_coil)) == '0))
        else $error("coil switched on during tick sweep");

    // The duty changes only as the divide finishes.
    a_duty_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_duty) |-> ($past(r_state) == ST_DIV))
        else $error("duty changed outside divide");

    // A new result appears only from the finishing state.
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside finishing state");

endmodule

// ----- tb/coil_pulse_checker.sv -----
module coil_pulse_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcpt_req_if         i_req,
    mcpt_res_if         i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcpt_pkg::*;

    localparam int NOTES = NOTES_DEF;

    typedef struct packed {
        logic [MASK_W-1:0] coil_mask;
        logic [DUTY_W-1:0] drive_duty;
        logic              strike_taken;
    } t_coil_state;

    // Shadow copy of the configuration registers.
    logic [NOTE_W-1:0] start_note_q;
    logic [HIT_W-1:0]  hit_time_q;
    logic [DUTY_W-1:0] min_pwm_q;
    logic [MASK_W-1:0] note_en_q;

    // Shadow copy of the coil timers and the shared duty.
    logic [MASK_W-1:0] coils_on;
    logic [HIT_W-1:0]  coil_ms [NOTES];
    logic [DUTY_W-1:0] duty_now;

    t_coil_state coil_states_due[$];
    int          mismatches = 0;

    // Applies one request to the shadow state and returns the coil state it leaves.
    function automatic t_coil_state play_request(input logic [FUNC_W-1:0] func,
                                                 input logic [NOTE_W-1:0] note,
                                                 input logic [VEL_W-1:0]  vel);
        t_coil_state r;
        int          idx;
        r.strike_taken = 1'b0;
        if (func == FUNC_STRIKE) begin
            idx = int'(note) - int'(start_note_q);
            if (idx >= 0 && idx < NOTES && note_en_q[idx]) begin
                coils_on[idx] = 1'b1;
                coil_ms[idx]  = '0;
                duty_now = DUTY_W'(int'(min_pwm_q) + int'(vel) *
                           (int'(DUTY_MAX) - int'(min_pwm_q)) / int'(VEL_MAX));
                r.strike_taken = 1'b1;
            end
        end else begin
            // One millisecond: advance every live coil, saturating at the hit time.
            for (int i = 0; i < NOTES; i++) begin
                if (coils_on[i]) begin
                    if (coil_ms[i] < hit_time_q) coil_ms[i] = coil_ms[i] + HIT_W'(1);
                    if (coil_ms[i] >= hit_time_q) coils_on[i] = 1'b0;
                end
            end
        end
        r.coil_mask  = coils_on;
        r.drive_duty = duty_now;
        return r;
    endfunction

    task automatic flag_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_coil_state seen;
        t_coil_state want;
        if (!i_rst_n) begin
            start_note_q = START_NOTE_RST;
            hit_time_q   = HIT_TIME_RST;
            min_pwm_q    = MIN_PWM_RST;
            note_en_q    = NOTE_EN_RST;
            coils_on     = '0;
            duty_now     = '0;
            for (int i = 0; i < NOTES; i++) coil_ms[i] = '0;
            coil_states_due.delete();
        end else begin
            // Register writes land at the access cycle.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_START_NOTE: start_note_q = pwdata[NOTE_W-1:0];
                    REG_HIT_TIME:   hit_time_q   = pwdata[HIT_W-1:0];
                    REG_MIN_PWM:    min_pwm_q    = pwdata[DUTY_W-1:0];
                    REG_NOTE_EN:    note_en_q    = pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end

            // Each accepted request queues the coil state it should produce.
            if (i_req.valid && i_req.ready) begin
                coil_states_due.push_back(play_request(i_req.func, i_req.note,
                                                       i_req.velocity));
            end

            // Each accepted result is matched against the oldest expectation.
            if (i_res.valid && i_res.ready) begin
                seen.coil_mask    = i_res.coil_mask;
                seen.drive_duty   = i_res.drive_duty;
                seen.strike_taken = i_res.strike_taken;
                if (coil_states_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got mask %h duty %h taken %b",
                             $time, seen.coil_mask, seen.drive_duty, seen.strike_taken);
                    mismatches++;
                end else begin
                    want = coil_states_due.pop_front();
                    if (seen.coil_mask !== want.coil_mask)
                        flag_field("coil_mask", 32'(want.coil_mask), 32'(seen.coil_mask));
                    if (seen.drive_duty !== want.drive_duty)
                        flag_field("drive_duty", 32'(want.drive_duty), 32'(seen.drive_duty));
                    if (seen.strike_taken !== want.strike_taken)
                        flag_field("strike_taken", 32'(want.strike_taken),
                                   32'(seen.strike_taken));
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= coil_states_due.size();
    end

endmodule

// ----- tb/tb_multi_coil_pulse_timer.sv -----
module tb_multi_coil_pulse_timer;
    timeunit 1ns;
    timeprecision 1ps;
    import mcpt_pkg::*;

    localparam int NOTES          = NOTES_DEF;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 125;
    localparam int DRAIN_CYCLES   = NOTES + 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          quiet_cycles = 0;
    int          error_count;
    int          results_owed;
    logic [NOTE_W-1:0] start_now = START_NOTE_RST;

    mcpt_req_if req_ch ();
    mcpt_res_if res_ch ();

    multi_coil_pulse_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    coil_pulse_checker pulse_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (error_count),
        .o_pending (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_multi_coil_pulse_timer: errors");
            $finish;
        end
    end

    // Sends one request; entered and left at a falling edge, valid left high.
    task automatic push_request(input logic [FUNC_W-1:0] func, input logic [NOTE_W-1:0] note,
                                input logic [VEL_W-1:0] vel);
        while ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.func     = func;
        req_ch.note     = note;
        req_ch.velocity = vel;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every result has come back.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (results_owed != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly strikes on mapped notes and ticks; some strikes anywhere.
    task automatic random_request();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 45) begin
            push_request(FUNC_TICK, NOTE_W'($urandom), VEL_W'($urandom));
        end else if (pick < 85) begin
            n = int'(start_now) + $urandom_range(0, NOTES - 1);
            if (n > 127) n = $urandom_range(0, 127);
            push_request(FUNC_STRIKE, NOTE_W'(n), VEL_W'($urandom));
        end else begin
            push_request(FUNC_STRIKE, NOTE_W'($urandom), VEL_W'($urandom));
        end
    endtask

    // Register settings per phase, extremes included.
    task automatic set_phase(input int ph);
        logic [NOTE_W-1:0] sn;
        logic [HIT_W-1:0]  ht;
        logic [DUTY_W-1:0] pw;
        logic [MASK_W-1:0] en;
        case (ph)
            0: begin
                sn = '0;       ht = 16'd20;  pw = '0;  en = '1;
            end
            1: begin
                sn = 7'd96;    ht = '1;      pw = '1;  en = $urandom;
            end
            2: begin
                // Far shorter hit time while coils from the last phase still run.
                sn = 7'd96;    ht = 16'd3;   pw = 8'd100; en = '1;
            end
            3: begin
                sn = 7'd127;   ht = '0;      pw = DUTY_W'($urandom); en = '1;
            end
            4: begin
                sn = NOTE_W'($urandom_range(0, 100)); ht = HIT_W'($urandom_range(1, 50));
                pw = DUTY_W'($urandom); en = $urandom;
            end
            5: begin
                sn = 7'd40;    ht = 16'd10;  pw = '1;  en = '0;
            end
            6: begin
                sn = NOTE_W'($urandom_range(0, 127)); ht = HIT_W'($urandom_range(1, 12));
                pw = DUTY_W'($urandom); en = $urandom;
            end
            default: begin
                sn = START_NOTE_RST; ht = HIT_TIME_RST; pw = MIN_PWM_RST; en = NOTE_EN_RST;
            end
        endcase
        write_reg(REG_START_NOTE, 32'(sn));
        write_reg(REG_HIT_TIME, 32'(ht));
        write_reg(REG_MIN_PWM, 32'(pw));
        write_reg(REG_NOTE_EN, en);
        start_now = sn;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_STRIKE;
        req_ch.note     = '0;
        req_ch.velocity = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests at the reset settings: coil range edges, notes just
        // outside it, extreme velocities, a restrike and ticks with junk fields.
        push_request(FUNC_STRIKE, 7'd60, 7'd127);
        push_request(FUNC_STRIKE, 7'd91, 7'd0);
        push_request(FUNC_STRIKE, 7'd92, 7'd64);
        push_request(FUNC_STRIKE, 7'd59, 7'd100);
        push_request(FUNC_STRIKE, 7'd0, 7'd127);
        push_request(FUNC_STRIKE, 7'd127, 7'd0);
        push_request(FUNC_TICK, 7'd127, 7'd127);
        push_request(FUNC_TICK, 7'd0, 7'd0);
        push_request(FUNC_STRIKE, 7'd60, 7'd1);
        push_request(FUNC_STRIKE, 7'd75, 7'd64);
        push_request(FUNC_TICK, 7'd85, 7'd42);
        push_request(FUNC_TICK, 7'd21, 7'd85);

        // A disabled note is refused while its neighbor is taken.
        drain();
        write_reg(REG_NOTE_EN, ~(32'd1 << 5));
        push_request(FUNC_STRIKE, 7'd65, 7'd90);
        push_request(FUNC_STRIKE, 7'd66, 7'd90);
        push_request(FUNC_TICK, 7'd0, 7'd0);

        // Random phases, each with its own settings and idling mode.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            set_phase(ph);
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 69; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 69; end
                default: begin send_gap_pct = 21; stall_pct = 21; end
            endcase
            repeat ((ph == 5) ? 40 : PHASE_REQUESTS) random_request();
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb_multi_coil_pulse_timer: clean");
        end else begin
            $display("tb_multi_coil_pulse_timer: errors");
        end
        $finish;
    end

endmodule
